// File: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH = 64;

  // Request codes carried in the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // What a cell passes to its right neighbor.
  typedef struct packed {
    entry_t entry;
    logic   keep;  // entry stays in place on insert (priority <= new one)
  } link_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  // Broadcast command to every cell.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } cmd_t;

endpackage

// File: sv/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  link_t  left,
  input  entry_t right,
  output link_t  own
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   keep;

  assign keep = entry_r.valid && (entry_r.prio <= cmd.prio);

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      OP_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left.keep) begin
          // first slot past the priorities not above the new one: take the new entry
          entry_nxt.valid = 1'b1;
          entry_nxt.value = cmd.value;
          entry_nxt.prio  = cmd.prio;
        end else begin
          entry_nxt = left.entry;
        end
      end
      OP_REMOVE: entry_nxt = right;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.value <= entry_nxt.value;
    entry_r.prio  <= entry_nxt.prio;
  end

  assign own.entry = entry_r;
  assign own.keep  = keep;

endmodule

// File: sv/sorted_priority_queue_top.sv
// Sorted priority queue: a chain of cells kept in ascending priority order.
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle unless held off; set by the single chain update.
// A request is held off only while the output register holds an untaken result.
// Reset (synchronous, active low) empties every cell and the output register.
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  link_t  links [DEPTH];
  cmd_t   cmd;
  logic   accept;
  logic   full;
  logic   empty;
  logic   out_valid_r;
  logic   out_valid_nxt;
  out_t   out_data_r;
  out_t   out_data_nxt;

  localparam link_t HEAD_LINK = '{entry: '0, keep: 1'b1};
  localparam entry_t NO_ENTRY = '0;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = links[DEPTH-1].entry.valid;
  assign empty    = !links[0].entry.valid;

  always_comb begin
    cmd.op       = OP_HOLD;
    cmd.value    = in_data.item_value;
    cmd.prio     = in_data.item_priority;
    out_data_nxt = '0;
    if (in_data.action == ACT_INSERT) begin
      out_data_nxt.status = full ? ST_FULL : ST_OK;
      if (accept && !full) begin
        cmd.op = OP_INSERT;
      end
    end else begin
      if (empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.status       = ST_OK;
        out_data_nxt.out_value    = links[0].entry.value;
        out_data_nxt.out_priority = links[0].entry.prio;
        if (accept) begin
          cmd.op = OP_REMOVE;
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t  left_in;
    entry_t right_in;
    if (i == 0) begin : g_head
      assign left_in = HEAD_LINK;
    end else begin : g_body
      assign left_in = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = NO_ENTRY;
    end else begin : g_mid
      assign right_in = links[i+1].entry;
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .own   (links[i])
    );
  end

  // Load on every accepted request; drop the result once its transfer completes.
  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
